@@ hw/rtl/aciarx_pkg.sv @@
// Shared types and constants of the ACIA register block with receive queue.
// Holds queue sizing, status and command bit masks, codes and reset values.
// No dependencies.
package aciarx_pkg;

    localparam int QUEUE_DEPTH = 8192;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int USED_W      = PTR_W + 1;

    localparam int PACE_W     = 12;
    localparam int AGE_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [AGE_W-1:0]  AGE_MAX          = '1;
    localparam logic [PACE_W-1:0] PACE_RESET       = 12'd2300;
    localparam logic [AGE_W-1:0]  TIMEOUT_RESET    = 10'd300;

    localparam logic [7:0] ST_IRQ     = 8'h80;
    localparam logic [7:0] ST_TXEMPTY = 8'h10;
    localparam logic [7:0] ST_RXFULL  = 8'h08;
    localparam logic [7:0] CMD_RXOFF  = 8'h02;
    localparam logic [7:0] CMD_RESET  = 8'hE0;

    typedef enum logic [2:0] {
        ACT_READ    = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_NET     = 3'd2,
        ACT_TICK    = 3'd3,
        ACT_TX_SERV = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_DATA    = 2'd0,
        REG_STATUS  = 2'd1,
        REG_COMMAND = 2'd2,
        REG_CONTROL = 2'd3
    } reg_addr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACE    = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_idx_t;

    // Result item, first field in the highest bits.
    typedef struct packed {
        logic       overflow;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq_line;
        logic [7:0] read_data;
    } aciarx_res_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [USED_W-1:0] queue_used(input logic [PTR_W-1:0] head,
                                                      input logic [PTR_W-1:0] tail);
        logic [USED_W-1:0] h;
        logic [USED_W-1:0] t;
        h = {1'b0, head};
        t = {1'b0, tail};
        if (head >= tail) begin
            return h - t;
        end
        return h + USED_W'(QUEUE_DEPTH) - t;
    endfunction

endpackage

@@ hw/rtl/aciarx_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the receive ring of the ACIA block. No dependencies.
module aciarx_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/acia_registers_with_rx_queue_unit.sv @@
// Top level of the emulated 6551 ACIA register block with receive ring queue.
// Depends on aciarx_pkg and aciarx_ram.
//
// Usage:
//   The slave channel takes one item per bus access, network byte, tick or
//   transmit service: s_tuser carries the action and register address,
//   s_tdata the data byte and the host link flag. Every item yields exactly
//   one result item on the master channel: read data, IRQ line, transmit
//   byte with its valid flag and the queue overflow flag.
//   One item is accepted per clock while s_tready is high; its result is
//   registered onto m_tdata. The rate is set by the ring RAM, which takes
//   one write (push) and one read (delivery) per cycle; a delivered byte
//   leaves the RAM read register in the next cycle, forwarded to the next item.
//   A two-entry output stage (output register plus skid register) lets one
//   more item in while a result waits; s_tready drops only when both hold
//   results the receiver has not taken.
//   Reset clears pointers and registers to their power-up values and loads
//   the default pacing and timeout; the ring contents are not cleared, so
//   the block is ready as soon as reset is released.
//   Configuration writes are taken at any edge with cfg_wr_en high and are
//   meant to happen while the block is idle.
module acia_registers_with_rx_queue_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] data_in, [8] host_connected, [15:9] zero
    input  logic [15:0]                         s_tdata,
    // [2:0] action, [4:3] reg_addr
    input  logic [4:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] read_data, [8] irq_line, [9] tx_valid, [17:10] tx_byte,
    // [18] overflow, [23:19] zero
    output logic [23:0]                         m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [aciarx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aciarx_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import aciarx_pkg::*;

    logic [PACE_W-1:0] pace_cfg_reg;
    logic [AGE_W-1:0]  timeout_cfg_reg;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [7:0]        status_reg, status_next;
    logic [7:0]        command_reg, command_next;
    logic [7:0]        control_reg, control_next;
    logic [7:0]        rx_holding_reg;
    logic [7:0]        tx_holding_reg, tx_holding_next;
    logic [PACE_W-1:0] pace_reg, pace_next;
    logic [AGE_W-1:0]  age_reg, age_next;

    // A delivered byte is still in the RAM read register (or the forward
    // register when it was written by the same item).
    logic              rd_pend_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_byte_reg;
    logic [7:0]        rx_holding_eff;

    logic              in_acc;
    action_t           act;
    reg_addr_t         raddr;
    logic [7:0]        data_in;
    logic              host_conn;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_wa;
    logic [7:0]        ram_wd;
    logic              deliver;
    logic [PTR_W-1:0]  ram_ra;
    logic [7:0]        ram_rdata;

    aciarx_res_t       res;
    aciarx_res_t       out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    assign s_tready  = ~skid_valid_reg;
    assign in_acc    = s_tvalid & s_tready;
    assign act       = action_t'(s_tuser[2:0]);
    assign raddr     = reg_addr_t'(s_tuser[4:3]);
    assign data_in   = s_tdata[7:0];
    assign host_conn = s_tdata[8];

    assign rx_holding_eff = rd_pend_reg ? (fwd_hit_reg ? fwd_byte_reg : ram_rdata)
                                        : rx_holding_reg;

    aciarx_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (8)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (deliver),
        .rd_addr (ram_ra),
        .rd_data (ram_rdata)
    );

    always_comb begin
        logic push_req;
        logic [7:0] push_byte;
        head_next       = head_reg;
        tail_next       = tail_reg;
        status_next     = status_reg;
        command_next    = command_reg;
        control_next    = control_reg;
        tx_holding_next = tx_holding_reg;
        pace_next       = pace_reg;
        age_next        = age_reg;
        push_req        = 1'b0;
        push_byte       = data_in;
        ram_we          = 1'b0;
        ram_wa          = head_reg;
        ram_wd          = data_in;
        ram_ra          = tail_reg;
        deliver         = 1'b0;
        res             = '0;

        if (in_acc) begin
            case (act)
                ACT_READ: begin
                    case (raddr)
                        REG_DATA: begin
                            res.read_data = rx_holding_eff;
                            pace_next     = pace_cfg_reg;
                            status_next   = status_next & ~(ST_RXFULL | ST_IRQ);
                        end
                        REG_STATUS:  res.read_data = status_reg;
                        REG_COMMAND: res.read_data = command_reg;
                        REG_CONTROL: res.read_data = control_reg;
                        default:     res.read_data = '0;
                    endcase
                end
                ACT_WRITE: begin
                    case (raddr)
                        REG_DATA: begin
                            tx_holding_next = data_in;
                            status_next     = status_next & ~ST_TXEMPTY;
                        end
                        REG_STATUS:  command_next = CMD_RESET;
                        REG_COMMAND: command_next = data_in;
                        REG_CONTROL: control_next = data_in;
                        default:     command_next = command_reg;
                    endcase
                end
                ACT_NET: push_req = 1'b1;
                ACT_TICK: begin
                    if (pace_reg != '0) begin
                        pace_next = pace_reg - 1'b1;
                    end
                    if (age_reg != AGE_MAX) begin
                        age_next = age_reg + 1'b1;
                    end
                end
                ACT_TX_SERV: begin
                    if ((status_reg & ST_TXEMPTY) == '0) begin
                        if (host_conn) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = tx_holding_reg;
                        end else begin
                            push_req  = 1'b1;
                            push_byte = tx_holding_reg;
                        end
                        status_next = status_next | ST_TXEMPTY;
                    end
                end
                default: push_req = 1'b0;
            endcase

            if (push_req) begin
                if (queue_used(head_reg, tail_reg) >= USED_W'(QUEUE_DEPTH - 1)) begin
                    head_next    = '0;
                    tail_next    = '0;
                    status_next  = status_next & ~(ST_RXFULL | ST_IRQ);
                    res.overflow = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wd    = push_byte;
                    head_next = ptr_inc(head_reg);
                end
            end

            ram_ra  = tail_next;
            deliver = (head_next != tail_next) && ((command_next & CMD_RXOFF) == '0) &&
                      ((status_next & (ST_RXFULL | ST_IRQ)) == '0) && (pace_next == '0);
            if (deliver) begin
                tail_next   = ptr_inc(tail_next);
                status_next = status_next | ST_RXFULL | ST_IRQ;
                age_next    = '0;
            end

            if (((status_next & ST_IRQ) != '0) && (age_next > timeout_cfg_reg)) begin
                status_next = status_next & ~(ST_RXFULL | ST_IRQ);
            end

            res.irq_line = (status_next & ST_IRQ) != '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pace_cfg_reg    <= PACE_RESET;
            timeout_cfg_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PACE:    pace_cfg_reg    <= cfg_wdata;
                CFG_TIMEOUT: timeout_cfg_reg <= cfg_wdata[AGE_W-1:0];
                default:     pace_cfg_reg    <= pace_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            status_reg     <= ST_TXEMPTY;
            command_reg    <= CMD_RESET;
            control_reg    <= '0;
            rx_holding_reg <= '0;
            tx_holding_reg <= '0;
            pace_reg       <= '0;
            age_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            status_reg     <= status_next;
            command_reg    <= command_next;
            control_reg    <= control_next;
            tx_holding_reg <= tx_holding_next;
            pace_reg       <= pace_next;
            age_reg        <= age_next;
            if (rd_pend_reg) begin
                rx_holding_reg <= rx_holding_eff;
            end
            rd_pend_reg <= deliver;
            // A byte pushed into an empty queue is read back in the same cycle.
            fwd_hit_reg <= deliver && ram_we && (ram_wa == ram_ra);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_byte_reg <= ram_wd;
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (in_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (in_acc) begin
                skid_reg <= res;
            end
        end else if (skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (in_acc) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg};

    // A flush empties the queue, so nothing can be delivered behind it.
    a_ovf_no_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && res.overflow |-> !res.irq_line)
        else $error("overflow result with IRQ set");

    // A pending delivery always leaves the IRQ bit set.
    a_pend_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (status_reg & ST_IRQ) != '0)
        else $error("delivered byte without IRQ");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while output is empty");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_used(head_reg, tail_reg) < USED_W'(QUEUE_DEPTH))
        else $error("queue fill out of range");

endmodule

@@ tb/sv/acia_result_check.sv @@
// Result checker for the ACIA register block with receive queue.
// Watches both stream channels and the register write port, predicts each result
// item and compares it field by field. Depends on aciarx_pkg.
`timescale 1ns / 100ps

module acia_result_check
    import aciarx_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic [4:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    result_errors,
    output int                    results_due
);

    // Predicted block state.
    logic [7:0]        rx_ring [QUEUE_DEPTH];
    int                rx_head;
    int                rx_tail;
    logic [7:0]        status_reg;
    logic [7:0]        command_reg;
    logic [7:0]        control_reg;
    logic [7:0]        rx_hold;
    logic [7:0]        tx_hold;
    logic [PACE_W-1:0] pace_count;
    logic [AGE_W-1:0]  irq_age;
    logic [PACE_W-1:0] pace_cfg;
    logic [AGE_W-1:0]  timeout_cfg;

    aciarx_res_t       awaited_results [$];
    int                results_seen;

    initial begin
        result_errors = 0;
        results_due   = 0;
        results_seen  = 0;
    end

    function automatic int ring_fill();
        return (rx_head - rx_tail + QUEUE_DEPTH) % QUEUE_DEPTH;
    endfunction

    // A push into a ring that already holds depth-1 bytes drops the byte and
    // empties the ring instead.
    function automatic logic ring_push(input logic [7:0] b);
        if (ring_fill() >= QUEUE_DEPTH - 1) begin
            rx_head = 0;
            rx_tail = 0;
            status_reg &= ~(ST_RXFULL | ST_IRQ);
            return 1'b1;
        end
        rx_ring[rx_head] = b;
        rx_head = (rx_head + 1) % QUEUE_DEPTH;
        return 1'b0;
    endfunction

    task automatic apply_item(input logic [2:0] act, input logic [1:0] addr,
                              input logic [7:0] val, input logic conn,
                              output aciarx_res_t r);
        r = '0;
        case (act)
            ACT_READ: begin
                case (addr)
                    REG_DATA: begin
                        r.read_data = rx_hold;
                        pace_count  = pace_cfg;
                        status_reg &= ~(ST_RXFULL | ST_IRQ);
                    end
                    REG_STATUS:  r.read_data = status_reg;
                    REG_COMMAND: r.read_data = command_reg;
                    default:     r.read_data = control_reg;
                endcase
            end
            ACT_WRITE: begin
                case (addr)
                    REG_DATA: begin
                        tx_hold = val;
                        status_reg &= ~ST_TXEMPTY;
                    end
                    REG_STATUS:  command_reg = CMD_RESET;
                    REG_COMMAND: command_reg = val;
                    default:     control_reg = val;
                endcase
            end
            ACT_NET: r.overflow = ring_push(val);
            ACT_TICK: begin
                if (pace_count != '0) pace_count = pace_count - 1'b1;
                if (irq_age != AGE_MAX) irq_age = irq_age + 1'b1;
            end
            ACT_TX_SERV: begin
                if ((status_reg & ST_TXEMPTY) == '0) begin
                    if (conn) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_hold;
                    end else begin
                        r.overflow = ring_push(tx_hold);
                    end
                    status_reg |= ST_TXEMPTY;
                end
            end
            default: ;
        endcase

        if (ring_fill() > 0 && (command_reg & CMD_RXOFF) == '0 &&
            (status_reg & (ST_RXFULL | ST_IRQ)) == '0 && pace_count == '0) begin
            rx_hold = rx_ring[rx_tail];
            rx_tail = (rx_tail + 1) % QUEUE_DEPTH;
            status_reg |= (ST_RXFULL | ST_IRQ);
            irq_age = '0;
        end

        if ((status_reg & ST_IRQ) != '0 && irq_age > timeout_cfg)
            status_reg &= ~(ST_RXFULL | ST_IRQ);

        r.irq_line = ((status_reg & ST_IRQ) != '0);
    endtask

    always @(posedge aclk) begin
        aciarx_res_t want;
        aciarx_res_t got;
        if (!aresetn) begin
            rx_head     = 0;
            rx_tail     = 0;
            status_reg  = ST_TXEMPTY;
            command_reg = CMD_RESET;
            control_reg = '0;
            rx_hold     = '0;
            tx_hold     = '0;
            pace_count  = '0;
            irq_age     = '0;
            pace_cfg    = PACE_RESET;
            timeout_cfg = TIMEOUT_RESET;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PACE:    pace_cfg    = cfg_wdata[PACE_W-1:0];
                    CFG_TIMEOUT: timeout_cfg = cfg_wdata[AGE_W-1:0];
                    default: ;
                endcase
            end

            // A result leaves from the output register, never in the cycle of its item, so
            // it is matched before the item of this edge is predicted.
            if (m_tvalid && m_tready) begin
                got = aciarx_res_t'(m_tdata[18:0]);
                if (awaited_results.size() == 0) begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display("unexpected result item %0d: %06h", results_seen, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.read_data !== want.read_data || got.irq_line !== want.irq_line ||
                        got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                        got.overflow !== want.overflow) begin
                        result_errors++;
                        if (result_errors <= 10)
                            $display({"result item %0d: expected rd=%02h irq=%b txv=%b ",
                                      "txb=%02h ovf=%b, got rd=%02h irq=%b txv=%b ",
                                      "txb=%02h ovf=%b"},
                                     results_seen, want.read_data, want.irq_line,
                                     want.tx_valid, want.tx_byte, want.overflow,
                                     got.read_data, got.irq_line, got.tx_valid,
                                     got.tx_byte, got.overflow);
                    end
                end
                results_seen++;
            end

            if (s_tvalid && s_tready) begin
                apply_item(s_tuser[2:0], s_tuser[4:3], s_tdata[7:0], s_tdata[8], want);
                awaited_results.push_back(want);
            end
        end
        results_due = awaited_results.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the testbench for the ACIA register block with receive queue.
// Generates clock, reset, register writes and item traffic with random gaps and
// stalls; depends on aciarx_pkg, acia_result_check and the block itself.
`timescale 1ns / 100ps

module tb;
    import aciarx_pkg::*;

    localparam int         IDLE_LIMIT    = 2000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_ITEMS   = 120;
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic [4:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int result_errors;
    int results_due;
    int burst_left = 0;
    int idle_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    acia_registers_with_rx_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    acia_result_check check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .result_errors (result_errors),
        .results_due   (results_due)
    );

    // Receiver: stretches of always-ready, coin-flip and mostly-stalled, plus one
    // long hold-off on request so that the block backs up into its input.
    always begin
        int stall_left;
        int stall_mode;
        stall_left = 0;
        stall_mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(1, 30);
                end
                stall_left--;
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic offer(input logic [2:0] act, input logic [1:0] addr,
                         input logic [7:0] val, input logic conn);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= {addr, act};
        s_tdata  <= {7'd0, conn, val};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drops valid and waits until every result item has come back.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_config(input logic [PACE_W-1:0] pace, input logic [AGE_W-1:0] tmo);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PACE;
        cfg_wdata <= pace;
        @(negedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= {2'($urandom), tmo};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_bytes(input int count);
        repeat (count) offer(ACT_NET, 2'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic read_data_reg(input int count);
        repeat (count) offer(ACT_READ, REG_DATA, 8'($urandom), 1'($urandom));
    endtask

    task automatic mixed_traffic(input int count);
        int sent;
        int pick;
        int run;
        logic [1:0] addr;
        logic [7:0] val;
        logic conn;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            addr = 2'($urandom);
            val  = 8'($urandom);
            conn = 1'($urandom);
            if (pick < 20) begin
                offer(ACT_NET, addr, val, conn);
                sent++;
            end else if (pick < 32) begin
                // Runs of ticks let the pacing countdown and the IRQ age move on.
                run = $urandom_range(1, 12);
                repeat (run) offer(ACT_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
                sent += run;
            end else if (pick < 52) begin
                offer(ACT_READ, ($urandom_range(0, 2) == 0) ? addr : REG_DATA, val, conn);
                sent++;
            end else if (pick < 66) begin
                // Keep the receive interrupt enabled most of the time.
                if (addr == REG_COMMAND)
                    val = ($urandom_range(0, 3) == 0) ? (val | CMD_RXOFF) : (val & ~CMD_RXOFF);
                offer(ACT_WRITE, addr, val, conn);
                sent++;
            end else if (pick < 74) begin
                offer(ACT_WRITE, REG_DATA, val, conn);
                offer(ACT_TX_SERV, 2'($urandom), 8'($urandom), 1'($urandom));
                sent += 2;
            end else if (pick < 80) begin
                offer(ACT_TX_SERV, addr, val, conn);
                sent++;
            end else if (pick < 84) begin
                offer(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), addr, val, conn);
                sent++;
            end else if (pick < 92) begin
                offer(ACT_TICK, addr, val, conn);
                sent++;
            end else begin
                offer(ACT_READ, REG_STATUS, val, conn);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Power-up values, register round trips, delivery, transmit and echo.
        offer(ACT_READ, REG_STATUS, 8'h00, 1'b0);
        offer(ACT_READ, REG_COMMAND, 8'hFF, 1'b1);
        offer(ACT_READ, REG_CONTROL, 8'h00, 1'b0);
        offer(ACT_WRITE, REG_CONTROL, 8'hFF, 1'b1);
        offer(ACT_READ, REG_CONTROL, 8'h00, 1'b0);
        offer(ACT_WRITE, REG_CONTROL, 8'h00, 1'b0);
        offer(ACT_WRITE, REG_STATUS, 8'h5A, 1'b1);
        offer(ACT_WRITE, REG_COMMAND, 8'h00, 1'b0);
        offer(ACT_NET, REG_CONTROL, 8'hFF, 1'b1);
        offer(ACT_NET, REG_DATA, 8'h00, 1'b0);
        offer(ACT_READ, REG_STATUS, 8'h00, 1'b0);
        offer(ACT_READ, REG_DATA, 8'h00, 1'b0);
        offer(ACT_TICK, REG_DATA, 8'h00, 1'b0);
        offer(ACT_READ, REG_DATA, 8'hFF, 1'b1);
        offer(ACT_WRITE, REG_DATA, 8'hA5, 1'b0);
        offer(ACT_TX_SERV, REG_DATA, 8'h00, 1'b1);
        offer(ACT_TX_SERV, REG_DATA, 8'h00, 1'b1);
        offer(ACT_WRITE, REG_DATA, 8'h3C, 1'b1);
        offer(ACT_TX_SERV, REG_STATUS, 8'hFF, 1'b0);
        offer(ACT_SPARE_LO, REG_DATA, 8'h00, 1'b0);
        offer(ACT_SPARE_HI, REG_CONTROL, 8'hFF, 1'b1);
        offer(ACT_WRITE, REG_COMMAND, CMD_RXOFF, 1'b0);
        offer(ACT_READ, REG_COMMAND, 8'h00, 1'b0);
        offer(ACT_TICK, REG_CONTROL, 8'hFF, 1'b1);
        offer(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), REG_STATUS, 8'h81, 1'b0);
        settle();

        load_config(12'd0, 10'd1023);
        mixed_traffic(PHASE_ITEMS);
        settle();

        load_config(12'd4095, 10'd0);
        hold_req = 1'b1;
        mixed_traffic(PHASE_ITEMS);
        settle();

        load_config(12'd3, 10'd5);
        mixed_traffic(PHASE_ITEMS);
        settle();

        load_config(12'd0, 10'd0);
        mixed_traffic(PHASE_ITEMS);
        settle();

        load_config(12'($urandom_range(0, 40)), 10'($urandom_range(0, 60)));
        mixed_traffic(PHASE_ITEMS);
        settle();

        load_config(12'd12, 10'd30);
        mixed_traffic(PHASE_ITEMS);
        settle();

        // Back-to-back queue traffic: drain to empty, queue up a run of bytes
        // with delivery held off, then read them all back.
        no_gaps = 1'b1;
        load_config(12'd0, 10'd1023);
        offer(ACT_WRITE, REG_COMMAND, 8'h00, 1'b0);
        read_data_reg(20);
        offer(ACT_WRITE, REG_COMMAND, CMD_RXOFF, 1'b0);
        push_bytes(30);
        offer(ACT_WRITE, REG_COMMAND, 8'h00, 1'b0);
        read_data_reg(40);
        settle();

        repeat (10) @(negedge aclk);
        if (result_errors == 0 && results_due == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
